// File: rtl/ifps_pkg.sv
// Shared types and constants for the interpolating FIR pulse shaper.
package ifps_pkg;

  localparam int OP_LOAD   = 0;
  localparam int OP_FILTER = 1;

  localparam int REG_INTERP    = 0;
  localparam int REG_TAP_COUNT = 1;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;

  typedef struct packed {
    logic              operation;
    logic [5:0]        tap_index;
    logic signed [15:0] tap_re;
    logic signed [15:0] tap_im;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic [3:0]         phase;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } mac_state_t;

endpackage

// File: rtl/interpolating_fir_pulse_shaper_top.sv
// Top level of the complex polyphase interpolating FIR pulse shaper.
//  channel | direction | handshake      | payload
//  in      | input     | push / full    | in_item  (ifps_pkg::in_item_t)
//  out     | output    | pop / empty    | out_item (ifps_pkg::out_item_t)
//  cfg     | input     | cfg_we         | cfg_index, cfg_data
// A load request writes its tap as it is taken. A filter request runs, per phase p,
// the MAC over taps p, p+L, ... below n, with n = tap_count capped at MAX_TAPS,
// then drains and emits one result; the pace is set by the single shared complex
// MAC and one-port tap/history reads.
// Reset is synchronous; tap and history memories read as zero until written.
// A full result queue stalls the MAC engine; the input queue holds two requests.
module interpolating_fir_pulse_shaper_top #(
  parameter int MAX_TAPS   = 64,
  parameter int MAX_INTERP = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ifps_pkg::in_item_t   in_item,
  output logic                 empty,
  input  logic                 pop,
  output ifps_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [ifps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ifps_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic [4:0] interp_factor;
  logic [6:0] tap_count;
  logic       q_valid;
  logic       q_take;
  ifps_pkg::in_item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_factor <= 5'd4;
      tap_count     <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'(ifps_pkg::REG_INTERP)) interp_factor <= cfg_data[4:0];
      else tap_count <= cfg_data[6:0];
    end
  end

  ifps_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .q_valid, .q_take, .q_item
  );

  ifps_back #(.MAX_TAPS(MAX_TAPS), .MAX_INTERP(MAX_INTERP)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item,
    .interp_factor, .tap_count, .empty, .pop, .out_item
  );

endmodule

// File: rtl/ifps_front.sv
// Front end: input queue that holds requests until the MAC engine takes them.
module ifps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ifps_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_take,
  output ifps_pkg::in_item_t  q_item
);

  ifps_pkg::in_item_t slot [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // Store incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (full && !do_pop) |=> full)
    else $error("full dropped without pop");
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (!q_valid && !do_push) |=> !q_valid)
    else $error("queue became nonempty without push");

endmodule

// File: rtl/ifps_back.sv
// Back end: tap and history memories, shared complex MAC, output queue.
module ifps_back #(
  parameter int MAX_TAPS    = 64,
  parameter int MAX_INTERP  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_take,
  input  ifps_pkg::in_item_t q_item,
  input  logic [4:0]         interp_factor,
  input  logic [6:0]         tap_count,
  output logic               empty,
  input  logic               pop,
  output ifps_pkg::out_item_t out_item
);

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int PW  = (MAX_INTERP > 1) ? $clog2(MAX_INTERP) : 1;
  localparam int ACW = 32 + 2 + AW + 1;

  // Memories (read data registered)
  logic signed [15:0] coef_re_mem [MAX_TAPS];
  logic signed [15:0] coef_im_mem [MAX_TAPS];
  logic signed [15:0] hist_re_mem [MAX_TAPS];
  logic signed [15:0] hist_im_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] coef_vld;
  logic [MAX_TAPS-1:0] hist_vld;
  logic [AW-1:0] head;
  logic [AW-1:0] head_dec;
  logic [AW:0]   hsum;
  logic [AW-1:0] hrd;

  ifps_pkg::mac_state_t state, state_next;
  logic [AW:0]   k;
  logic [PW-1:0] p;
  logic [PW:0]   lsat;
  logic [AW:0]   nsat;
  logic [AW+PW+1:0] idx;
  logic          issue;
  logic          rd_v, mul_v;
  logic signed [15:0] tr, ti, hr, hi;
  logic signed [31:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [ACW-1:0] acc_re, acc_im;
  logic          is_load;

  // Output queue
  ifps_pkg::out_item_t oq [2];
  logic [1:0] oc;
  logic owp, orp, o_push, o_pop;
  ifps_pkg::out_item_t res;

  assign is_load = (q_item.operation == 1'(ifps_pkg::OP_LOAD));

  always_comb begin
    if (interp_factor == 5'd0) lsat = (PW+1)'(1);
    else if ({27'd0, interp_factor} > MAX_INTERP) lsat = (PW+1)'(MAX_INTERP);
    else lsat = (PW+1)'(interp_factor);
    if ({25'd0, tap_count} > MAX_TAPS) nsat = (AW+1)'(MAX_TAPS);
    else nsat = (AW+1)'(tap_count);
  end

  assign idx   = (AW+PW+2)'(k) * (AW+PW+2)'(lsat) + (AW+PW+2)'(p);
  assign issue = (state == ifps_pkg::ST_MAC) && (idx < (AW+PW+2)'(nsat))
                 && (k < (AW+1)'(MAX_TAPS));

  // Wrap history addresses around the line depth
  assign head_dec = (head == '0) ? AW'(MAX_TAPS - 1) : head - AW'(1);
  assign hsum     = {1'b0, head} + k;
  assign hrd      = (hsum >= (AW+1)'(MAX_TAPS)) ? AW'(hsum - (AW+1)'(MAX_TAPS))
                                                 : hsum[AW-1:0];

  // Sequencer
  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    o_push     = 1'b0;
    unique case (state)
      ifps_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (!is_load) state_next = ifps_pkg::ST_MAC;
        end
      end
      ifps_pkg::ST_MAC: begin
        if (!issue) state_next = ifps_pkg::ST_DRAIN;
      end
      ifps_pkg::ST_DRAIN: begin
        if (!rd_v && !mul_v) state_next = ifps_pkg::ST_EMIT;
      end
      ifps_pkg::ST_EMIT: begin
        if (oc != 2'd2) begin
          o_push = 1'b1;
          if ((PW+1)'(p) == lsat - (PW+1)'(1)) state_next = ifps_pkg::ST_IDLE;
          else state_next = ifps_pkg::ST_MAC;
        end
      end
      default: state_next = ifps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ifps_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Valid bits and history head
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      hist_vld <= '0;
      head     <= '0;
    end else if (state == ifps_pkg::ST_IDLE && q_valid) begin
      if (is_load) begin
        if ({26'd0, q_item.tap_index} < MAX_TAPS)
          coef_vld[AW'(q_item.tap_index)] <= 1'b1;
      end else begin
        hist_vld[head_dec] <= 1'b1;
        head <= head_dec;
      end
    end
  end

  // Write memories
  always_ff @(posedge clk) begin
    if (state == ifps_pkg::ST_IDLE && q_valid) begin
      if (is_load) begin
        if ({26'd0, q_item.tap_index} < MAX_TAPS) begin
          coef_re_mem[AW'(q_item.tap_index)] <= q_item.tap_re;
          coef_im_mem[AW'(q_item.tap_index)] <= q_item.tap_im;
        end
      end else begin
        hist_re_mem[head_dec] <= q_item.sample_re;
        hist_im_mem[head_dec] <= q_item.sample_im;
      end
    end
  end

  // Read taps and history, registered
  always_ff @(posedge clk) begin
    tr <= coef_vld[idx[AW-1:0]] ? coef_re_mem[idx[AW-1:0]] : 16'sd0;
    ti <= coef_vld[idx[AW-1:0]] ? coef_im_mem[idx[AW-1:0]] : 16'sd0;
    hr <= hist_vld[hrd] ? hist_re_mem[hrd] : 16'sd0;
    hi <= hist_vld[hrd] ? hist_im_mem[hrd] : 16'sd0;
    m_rr <= tr * hr;
    m_ii <= ti * hi;
    m_ri <= tr * hi;
    m_ir <= ti * hr;
  end

  // Step counters and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      k     <= '0;
      p     <= '0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
      if (issue) k <= k + (AW+1)'(1);
      if (state == ifps_pkg::ST_IDLE) begin
        p <= '0;
        k <= '0;
      end else if (o_push) begin
        p <= p + PW'(1);
        k <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ifps_pkg::ST_IDLE || o_push) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (mul_v) begin
      acc_re <= acc_re + ACW'(m_rr) - ACW'(m_ii);
      acc_im <= acc_im + ACW'(m_ri) + ACW'(m_ir);
    end
  end

  function automatic logic signed [15:0] rsat(input logic signed [ACW-1:0] a);
    logic signed [ACW-1:0] r;
    r = (a + ACW'(16384)) >>> 15;
    if (r > ACW'(32767)) return 16'sd32767;
    else if (r < -ACW'(32768)) return -16'sd32768;
    else return r[15:0];
  endfunction

  always_comb begin
    res.out_re      = rsat(acc_re);
    res.out_im      = rsat(acc_im);
    res.phase       = 4'(p);
    res.last_of_run = ((PW+1)'(p) == lsat - (PW+1)'(1));
  end

  // Result queue
  assign empty    = (oc == 2'd0);
  assign out_item = oq[orp];
  assign o_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (o_push) oq[owp] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oc  <= 2'd0;
      owp <= 1'b0;
      orp <= 1'b0;
    end else begin
      if (o_push) owp <= ~owp;
      if (o_pop)  orp <= ~orp;
      oc <= oc + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  a_no_oq_overflow: assert property (@(posedge clk) disable iff (rst)
    o_push |-> (oc != 2'd2)) else $error("result queue overflow");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (state == ifps_pkg::ST_IDLE)) else $error("take while busy");
  a_issue_mac: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == ifps_pkg::ST_MAC)) else $error("stray read");
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ifps_pkg::ST_EMIT) |-> (!rd_v && !mul_v)) else $error("emit before drain");

endmodule
